### rtl/ssfh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssfh_pkg;

    // control that travels with every pipeline slot
    typedef struct packed {
        logic vld;   // slot holds an item
        logic live;  // item can still produce a hit
    } t_ctl;

    localparam int CFG_IDX_W  = 3;
    localparam int MIN_DIST_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_MIN_DIST = 3'd4
    } t_reg_idx;

    localparam logic [47:0]           RADIUS_RESET   = 48'd65536;
    localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 16'd1;

endpackage

`default_nettype wire

### rtl/ssfh_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned W x W multiply, split in halves, two register stages
module ssfh_mul #(
    parameter int W = 66
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [W-1:0]   i_x,
    input  wire logic [W-1:0]   i_y,
    output logic      [2*W-1:0] o_p
);

    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;
    localparam int PW = 2 * W;

    logic [2*LO-1:0]    r_ll;
    logic [LO+HI-1:0]   r_lh;
    logic [LO+HI-1:0]   r_hl;
    logic [2*HI-1:0]    r_hh;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      n_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= (2*LO)'(i_x[LO-1:0]) * (2*LO)'(i_y[LO-1:0]);
            r_lh <= (LO+HI)'(i_x[LO-1:0]) * (LO+HI)'(i_y[W-1:LO]);
            r_hl <= (LO+HI)'(i_x[W-1:LO]) * (LO+HI)'(i_y[LO-1:0]);
            r_hh <= (2*HI)'(i_x[W-1:LO]) * (2*HI)'(i_y[W-1:LO]);
        end
    end

    // recombine
    assign n_p = (PW'(r_hh) << (2*LO)) + ((PW'(r_lh) + PW'(r_hl)) << LO) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/ssfh_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one root bit of two square roots per cell, payload passes along
module ssfh_sqrt_cell
    import ssfh_pkg::*;
#(
    parameter int K   = 66,
    parameter int PLW = 135
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_ctl                  i_ctl,
    input  wire logic [1:0][2*K-1:0]   i_rad,
    input  wire logic [1:0][K+2:0]     i_rem,
    input  wire logic [1:0][K-1:0]     i_root,
    input  wire logic [PLW-1:0]        i_pay,
    output t_ctl                       o_ctl,
    output logic      [1:0][2*K-1:0]   o_rad,
    output logic      [1:0][K+2:0]     o_rem,
    output logic      [1:0][K-1:0]     o_root,
    output logic      [PLW-1:0]        o_pay
);

    localparam int RW = K + 3;

    t_ctl                   r_ctl;
    logic [1:0][2*K-1:0]    r_rad;
    logic [1:0][RW-1:0]     r_rem;
    logic [1:0][K-1:0]      r_root;
    logic [PLW-1:0]         r_pay;
    logic [1:0][2*K-1:0]    n_rad;
    logic [1:0][RW-1:0]     n_rem;
    logic [1:0][K-1:0]      n_root;

    // restoring step: bring down two bits, try root*4+1
    always_comb begin
        logic [RW-1:0] pre;
        logic [RW-1:0] trial;
        for (int l = 0; l < 2; l++) begin
            pre      = {i_rem[l][RW-3:0], i_rad[l][2*K-1:2*K-2]};
            trial    = {1'b0, i_root[l], 2'b01};
            n_rad[l] = i_rad[l] << 2;
            if (pre >= trial) begin
                n_rem[l]  = pre - trial;
                n_root[l] = {i_root[l][K-2:0], 1'b1};
            end else begin
                n_rem[l]  = pre;
                n_root[l] = {i_root[l][K-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pay  <= i_pay;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pay  = r_pay;

endmodule

`default_nettype wire

### rtl/ssfh_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one quotient bit of two divisions by the same divisor per cell
module ssfh_div_cell
    import ssfh_pkg::*;
#(
    parameter int AW  = 66,
    parameter int FW  = 32,
    parameter int PLW = 35
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_ctl                 i_ctl,
    input  wire logic [1:0][AW-1:0]   i_rem,
    input  wire logic [1:0][FW-1:0]   i_quo,
    input  wire logic [AW-1:0]        i_dvs,
    input  wire logic [PLW-1:0]       i_pay,
    output t_ctl                      o_ctl,
    output logic      [1:0][AW-1:0]   o_rem,
    output logic      [1:0][FW-1:0]   o_quo,
    output logic      [AW-1:0]        o_dvs,
    output logic      [PLW-1:0]       o_pay
);

    t_ctl                  r_ctl;
    logic [1:0][AW-1:0]    r_rem;
    logic [1:0][FW-1:0]    r_quo;
    logic [AW-1:0]         r_dvs;
    logic [PLW-1:0]        r_pay;
    logic [1:0][AW-1:0]    n_rem;
    logic [1:0][FW-1:0]    n_quo;

    // shift-subtract step
    always_comb begin
        logic [AW:0] dbl;
        logic [AW:0] dif;
        for (int l = 0; l < 2; l++) begin
            dbl = {i_rem[l], 1'b0};
            dif = dbl - {1'b0, i_dvs};
            if (dbl >= {1'b0, i_dvs}) begin
                n_rem[l] = dif[AW-1:0];
                n_quo[l] = {i_quo[l][FW-2:0], 1'b1};
            end else begin
                n_rem[l] = dbl[AW-1:0];
                n_quo[l] = {i_quo[l][FW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;
    assign o_pay = r_pay;

endmodule

`default_nettype wire

### rtl/segment_sphere_first_hit_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// segment   | i_valid / o_ready         | i_start_x..z, i_end_x..z (signed Q16.16)
// result    | o_valid / i_ready         | o_hit_found, o_hit_fraction (Q0.F)
// config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// one segment per cycle while the pipeline is not held; its length is set
// mostly by the square-root row (one root bit per cell, 2*COORD_WIDTH+2
// cells) and the divider row (one fraction bit per cell).
// reset is synchronous, active low, clears all slot valid bits and loads config reset values.
// the whole pipeline holds only when its last slot is full and the output
// register is full and not taken; bubbles keep moving otherwise.
module segment_sphere_first_hit_top
    import ssfh_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int FRACTION_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_z,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_hit_found,
    output logic [FRACTION_WIDTH-1:0]          o_hit_fraction,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int FW  = FRACTION_WIDTH;
    localparam int DW  = CW + 1;        // difference vectors
    localparam int PW  = 2 * DW;        // component products
    localparam int MW  = 2 * CW + 2;    // a and magnitudes of h, c
    localparam int HW  = 2 * CW + 3;    // signed h and c
    localparam int QW  = 2 * MW + 1;    // signed discriminant
    localparam int SN  = MW;            // square-root cells
    localparam int NW  = HW + 1;        // root numerators
    localparam int LW  = CW + 1;        // segment length
    localparam int SPL = MW + HW;
    localparam int DPL = LW + 2;

    // configuration registers
    logic signed [CW-1:0]      r_cx, r_cy, r_cz;
    logic [CW-2:0]             r_rad;
    logic [MIN_DIST_W-1:0]     r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADIUS_RESET[CW-2:0];
            r_min <= MIN_DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_cx  <= i_cfg_data;
                REG_CENTER_Y: r_cy  <= i_cfg_data;
                REG_CENTER_Z: r_cz  <= i_cfg_data;
                REG_RADIUS:   r_rad <= i_cfg_data[CW-2:0];
                REG_MIN_DIST: r_min <= i_cfg_data[MIN_DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: hold only when the last slot cannot leave
    logic adv;
    t_ctl r_s9_ctl;
    logic r_out_vld;

    assign adv     = !(r_s9_ctl.vld && r_out_vld && !i_ready);
    assign o_ready = adv;

    // stage 1: direction d = E - S and offset w = S - C
    t_ctl                 r_s1_ctl;
    logic signed [DW-1:0] r_s1_d [3];
    logic signed [DW-1:0] r_s1_w [3];
    logic [CW-2:0]        r_s1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (adv) begin
            r_s1_ctl.vld  <= i_valid;
            r_s1_ctl.live <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_d[0] <= DW'(i_end_x) - DW'(i_start_x);
            r_s1_d[1] <= DW'(i_end_y) - DW'(i_start_y);
            r_s1_d[2] <= DW'(i_end_z) - DW'(i_start_z);
            r_s1_w[0] <= DW'(i_start_x) - DW'(r_cx);
            r_s1_w[1] <= DW'(i_start_y) - DW'(r_cy);
            r_s1_w[2] <= DW'(i_start_z) - DW'(r_cz);
            r_s1_r    <= r_rad;
        end
    end

    // stage 2: component products
    t_ctl                 r_s2_ctl;
    logic signed [PW-1:0] r_s2_dd [3];
    logic signed [PW-1:0] r_s2_dw [3];
    logic signed [PW-1:0] r_s2_ww [3];
    logic [2*CW-3:0]      r_s2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (adv) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_s2_dd[k] <= PW'(r_s1_d[k]) * PW'(r_s1_d[k]);
                r_s2_dw[k] <= PW'(r_s1_d[k]) * PW'(r_s1_w[k]);
                r_s2_ww[k] <= PW'(r_s1_w[k]) * PW'(r_s1_w[k]);
            end
            r_s2_rr <= (2*CW-2)'(r_s1_r) * (2*CW-2)'(r_s1_r);
        end
    end

    // stage 3: quadratic terms a, h, c
    t_ctl                 r_s3_ctl;
    logic [MW-1:0]        r_s3_a;
    logic signed [HW-1:0] r_s3_h;
    logic signed [HW-1:0] r_s3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else if (adv) begin
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_a <= MW'(unsigned'(r_s2_dd[0])) + MW'(unsigned'(r_s2_dd[1]))
                    + MW'(unsigned'(r_s2_dd[2]));
            r_s3_h <= HW'(r_s2_dw[0]) + HW'(r_s2_dw[1]) + HW'(r_s2_dw[2]);
            r_s3_c <= HW'(r_s2_ww[0]) + HW'(r_s2_ww[1]) + HW'(r_s2_ww[2])
                    - HW'(signed'({1'b0, r_s2_rr}));
        end
    end

    // stages 4-5: h*h and a*|c| in split multipliers
    logic [MW-1:0]   hmag, cmag;
    logic [2*MW-1:0] hh, ac;
    logic signed [HW-1:0] neg_h, neg_c;

    assign neg_h = -r_s3_h;
    assign neg_c = -r_s3_c;
    assign hmag  = r_s3_h[HW-1] ? MW'(neg_h) : MW'(r_s3_h);
    assign cmag  = r_s3_c[HW-1] ? MW'(neg_c) : MW'(r_s3_c);

    ssfh_mul #(.W(MW)) u_mul_hh (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (hmag),
        .i_y   (hmag),
        .o_p   (hh)
    );

    ssfh_mul #(.W(MW)) u_mul_ac (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_s3_a),
        .i_y   (cmag),
        .o_p   (ac)
    );

    t_ctl                 r_s4_ctl, r_s5_ctl;
    logic [MW-1:0]        r_s4_a, r_s5_a;
    logic signed [HW-1:0] r_s4_h, r_s5_h;
    logic                 r_s4_cneg, r_s5_cneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
            r_s5_ctl <= '0;
        end else if (adv) begin
            r_s4_ctl <= r_s3_ctl;
            r_s5_ctl <= r_s4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_a    <= r_s3_a;
            r_s4_h    <= r_s3_h;
            r_s4_cneg <= r_s3_c[HW-1];
            r_s5_a    <= r_s4_a;
            r_s5_h    <= r_s4_h;
            r_s5_cneg <= r_s4_cneg;
        end
    end

    // stage 6: discriminant Q = h*h - a*c and hit precondition
    logic [QW-1:0] disc;
    t_ctl          r_s6_ctl;
    logic [2*MW-1:0]      r_s6_q;
    logic [MW-1:0]        r_s6_a;
    logic signed [HW-1:0] r_s6_h;

    assign disc = r_s5_cneg ? (QW'(hh) + QW'(ac)) : (QW'(hh) - QW'(ac));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ctl <= '0;
        end else if (adv) begin
            r_s6_ctl.vld  <= r_s5_ctl.vld;
            r_s6_ctl.live <= r_s5_ctl.live && (r_s5_a != '0)
                           && !disc[QW-1] && (disc != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s6_q <= disc[2*MW-1:0];
            r_s6_a <= r_s5_a;
            r_s6_h <= r_s5_h;
        end
    end

    // square-root row: lane 0 takes sqrt(Q), lane 1 takes sqrt(a)
    t_ctl                   sq_ctl  [SN+1];
    logic [1:0][2*SN-1:0]   sq_rad  [SN+1];
    logic [1:0][SN+2:0]     sq_rem  [SN+1];
    logic [1:0][SN-1:0]     sq_root [SN+1];
    logic [SPL-1:0]         sq_pay  [SN+1];

    assign sq_ctl[0]     = r_s6_ctl;
    assign sq_rad[0][0]  = r_s6_q;
    assign sq_rad[0][1]  = (2*SN)'(r_s6_a);
    assign sq_rem[0]     = '0;
    assign sq_root[0]    = '0;
    assign sq_pay[0]     = {r_s6_a, r_s6_h};

    for (genvar g = 0; g < SN; g++) begin : g_sqrt
        ssfh_sqrt_cell #(.K(SN), .PLW(SPL)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_ctl  (sq_ctl[g]),
            .i_rad  (sq_rad[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_pay  (sq_pay[g]),
            .o_ctl  (sq_ctl[g+1]),
            .o_rad  (sq_rad[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_pay  (sq_pay[g+1])
        );
    end

    // stage 7: root numerators -h -/+ s and range check 0 < n < a
    logic [MW-1:0]        sq_a;
    logic signed [HW-1:0] sq_h;
    logic signed [NW-1:0] num [2];
    logic [1:0]           n_ok;
    logic signed [NW-1:0] a_ext, s_ext;

    assign sq_a  = sq_pay[SN][SPL-1:HW];
    assign sq_h  = sq_pay[SN][HW-1:0];
    assign a_ext = NW'(signed'({1'b0, sq_a}));
    assign s_ext = NW'(signed'({1'b0, sq_root[SN][0]}));
    assign num[0] = -NW'(sq_h) - s_ext;
    assign num[1] = -NW'(sq_h) + s_ext;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_ok[l] = sq_ctl[SN].live && !num[l][NW-1] && (num[l] != '0)
                    && (num[l] < a_ext);
        end
    end

    t_ctl                r_s7_ctl;
    logic [1:0][MW-1:0]  r_s7_rem;
    logic [MW-1:0]       r_s7_a;
    logic [LW-1:0]       r_s7_len;
    logic [1:0]          r_s7_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ctl <= '0;
        end else if (adv) begin
            r_s7_ctl <= sq_ctl[SN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_s7_rem[l] <= n_ok[l] ? num[l][MW-1:0] : '0;
            end
            r_s7_a   <= sq_a;
            r_s7_len <= sq_root[SN][1][LW-1:0];
            r_s7_ok  <= n_ok;
        end
    end

    // divider row: fraction n / a, one bit per cell
    t_ctl                 dv_ctl [FW+1];
    logic [1:0][MW-1:0]   dv_rem [FW+1];
    logic [1:0][FW-1:0]   dv_quo [FW+1];
    logic [MW-1:0]        dv_dvs [FW+1];
    logic [DPL-1:0]       dv_pay [FW+1];

    assign dv_ctl[0] = r_s7_ctl;
    assign dv_rem[0] = r_s7_rem;
    assign dv_quo[0] = '0;
    assign dv_dvs[0] = r_s7_a;
    assign dv_pay[0] = {r_s7_len, r_s7_ok};

    for (genvar g = 0; g < FW; g++) begin : g_div
        ssfh_div_cell #(.AW(MW), .FW(FW), .PLW(DPL)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_ctl  (dv_ctl[g]),
            .i_rem  (dv_rem[g]),
            .i_quo  (dv_quo[g]),
            .i_dvs  (dv_dvs[g]),
            .i_pay  (dv_pay[g]),
            .o_ctl  (dv_ctl[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_quo  (dv_quo[g+1]),
            .o_dvs  (dv_dvs[g+1]),
            .o_pay  (dv_pay[g+1])
        );
    end

    // stage 8: distance along step, fraction times length
    t_ctl                  r_s8_ctl;
    logic [FW+LW-1:0]      r_s8_prod [2];
    logic [1:0][FW-1:0]    r_s8_quo;
    logic [1:0]            r_s8_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_ctl <= '0;
        end else if (adv) begin
            r_s8_ctl <= dv_ctl[FW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_s8_prod[l] <= (FW+LW)'(dv_quo[FW][l]) * (FW+LW)'(dv_pay[FW][DPL-1:2]);
            end
            r_s8_quo <= dv_quo[FW];
            r_s8_ok  <= dv_pay[FW][1:0];
        end
    end

    // stage 9: pick the nearer counting root
    logic [1:0]      cnt;
    logic            r_s9_hit;
    logic [FW-1:0]   r_s9_frac;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cnt[l] = r_s8_ok[l] && (r_s8_prod[l][FW+LW-1:FW] > LW'(r_min));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_ctl <= '0;
        end else if (adv) begin
            r_s9_ctl <= r_s8_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s9_hit  <= |cnt;
            r_s9_frac <= cnt[0] ? r_s8_quo[0] : (cnt[1] ? r_s8_quo[1] : '0);
        end
    end

    // output register
    logic          r_out_hit;
    logic [FW-1:0] r_out_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_s9_ctl.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s9_ctl.vld) begin
            r_out_hit  <= r_s9_hit;
            r_out_frac <= r_s9_frac;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_hit_found    = r_out_hit;
    assign o_hit_fraction = r_out_frac;

    // a miss always reports a zero fraction
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_found |-> o_hit_fraction == '0)
        else $error("miss with nonzero fraction");

    // a full last slot facing a blocked output stalls the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s9_ctl.vld && r_out_vld && !i_ready |-> !o_ready)
        else $error("input accepted while pipeline is blocked");

    // a new result only comes from the last slot
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s9_ctl.vld))
        else $error("result appeared without a source item");

endmodule

`default_nettype wire
